// File: hdl/mhc_pkg.sv
// Shared types and constants of the Bayer demosaic block.
package mhc_pkg;

  // Configuration register indexes.
  localparam logic [7:0] REG_IMAGE_WIDTH  = 8'd0;
  localparam logic [7:0] REG_IMAGE_HEIGHT = 8'd1;

  // Input item commands.
  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_FLUSH = 1'b1;

  // Frame geometry that does not vary.
  localparam int DIM_W        = 13;
  localparam int ROW_W        = 12;
  localparam int MIN_DIM      = 3;
  localparam int HEIGHT_LIMIT = 4096;
  localparam int HEIGHT_RESET = 300;
  localparam int WIDTH_RESET  = 390;

  // Line store organisation: one slot per frame row modulo eight.
  localparam int LINE_SLOTS = 8;
  localparam int SLOT_W     = 3;

  // Kernel window and the job queue between the two halves.
  localparam int KSIZE       = 5;
  localparam int SEL_W       = 3;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;

  // Width of the signed kernel sums, in sixteenths.
  localparam int SUM_W = 15;

  // Work for the back half: one column read plus, for a result, the window map.
  typedef struct packed {
    logic                              emit;
    logic                              eof;
    logic                              rpar;
    logic                              cpar;
    logic [KSIZE-1:0][SLOT_W-1:0]      slot;
    logic [KSIZE-1:0][SEL_W-1:0]       sel;
  } job_t;

endpackage

// File: hdl/mhc_linebuf.sv
// Line store: eight row slots, one write and one common read column per cycle.
module mhc_linebuf #(
  parameter int MAX_WIDTH = 4096,
  localparam int AW = $clog2(MAX_WIDTH)
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [mhc_pkg::SLOT_W-1:0]            wslot,
  input  logic [AW-1:0]                         waddr,
  input  logic [7:0]                            wdata,
  input  logic                                  re,
  input  logic [AW-1:0]                         raddr,
  output logic [mhc_pkg::LINE_SLOTS-1:0][7:0]   rdata
);

  logic [7:0] mem [mhc_pkg::LINE_SLOTS][MAX_WIDTH];

  // Each slot is its own memory; all slots are read at the same column.
  always_ff @(posedge clk) begin
    for (int s = 0; s < mhc_pkg::LINE_SLOTS; s++) begin
      if (we && (wslot == mhc_pkg::SLOT_W'(s))) begin
        mem[s][waddr] <= wdata;
      end
      if (re) begin
        rdata[s] <= mem[s][raddr];
      end
    end
  end

endmodule

// File: hdl/mhc_jobq.sv
// Short job queue that decouples the front half from the back half.
module mhc_jobq #(
  parameter int DW = 32
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  logic [DW-1:0] din,
  input  logic          pop,
  output logic [DW-1:0] dout,
  output logic          full,
  output logic          empty
);

  logic [DW-1:0]              store [mhc_pkg::QUEUE_DEPTH];
  logic [mhc_pkg::QPTR_W-1:0] wptr;
  logic [mhc_pkg::QPTR_W-1:0] rptr;
  logic [mhc_pkg::QPTR_W:0]   count;

  assign full  = (count == (mhc_pkg::QPTR_W + 1)'(mhc_pkg::QUEUE_DEPTH));
  assign empty = (count == '0);
  assign dout  = store[rptr];

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push && !full) begin
        wptr <= wptr + mhc_pkg::QPTR_W'(1);
      end
      if (pop && !empty) begin
        rptr <= rptr + mhc_pkg::QPTR_W'(1);
      end
      if ((push && !full) && !(pop && !empty)) begin
        count <= count + (mhc_pkg::QPTR_W + 1)'(1);
      end else if (!(push && !full) && (pop && !empty)) begin
        count <= count - (mhc_pkg::QPTR_W + 1)'(1);
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push && !full) begin
      store[wptr] <= din;
    end
  end

endmodule

// File: hdl/mhc_front.sv
// Front half: configuration, frame counters, line store writes and job classification.
module mhc_front #(
  parameter int MAX_WIDTH = 4096,
  localparam int AW  = $clog2(MAX_WIDTH),
  localparam int WW  = $clog2(MAX_WIDTH + 1),
  localparam int LGW = WW + 2,
  localparam int CW  = (WW > mhc_pkg::DIM_W) ? WW : mhc_pkg::DIM_W,
  localparam int WID_RST = (MAX_WIDTH < mhc_pkg::WIDTH_RESET) ? MAX_WIDTH : mhc_pkg::WIDTH_RESET
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_wr,
  input  logic [7:0]                   cfg_index,
  input  logic [mhc_pkg::DIM_W-1:0]    cfg_data,
  input  logic                         acc,
  input  logic                         cmd,
  input  logic [7:0]                   raw_pixel,
  output logic                         we,
  output logic [mhc_pkg::SLOT_W-1:0]   wslot,
  output logic [AW-1:0]                waddr,
  output logic [7:0]                   wdata,
  output logic                         push,
  output mhc_pkg::job_t                job,
  output logic [AW-1:0]                job_col
);

  logic [WW-1:0]                wid;
  logic [mhc_pkg::DIM_W-1:0]    hgt;
  logic [AW-1:0]                in_col, in_col_next;
  logic [mhc_pkg::ROW_W-1:0]    in_row, in_row_next;
  logic                         in_done, in_done_next;
  logic [AW-1:0]                out_col, out_col_next;
  logic [mhc_pkg::ROW_W-1:0]    out_row, out_row_next;
  logic [LGW-1:0]               diff, diff_next;

  logic [WW-1:0]                wid_m1, wid_m2;
  logic [mhc_pkg::DIM_W-1:0]    hgt_m1, hgt_m2;
  logic [LGW-1:0]               lag;
  logic                         emit, pre, eof;
  logic                         c0, c1, ce0, ce1, wrap;
  logic [mhc_pkg::DIM_W-1:0]    rb;
  logic                         r0, r1, re0, re1;
  logic [mhc_pkg::SLOT_W-1:0]   rb3;
  logic [CW-1:0]                cfg_ext;

  assign wid_m1  = wid - WW'(1);
  assign wid_m2  = wid - WW'(2);
  assign hgt_m1  = hgt - mhc_pkg::DIM_W'(1);
  assign hgt_m2  = hgt - mhc_pkg::DIM_W'(2);
  assign lag     = (LGW'(wid) << 1) + LGW'(2);
  assign cfg_ext = CW'(cfg_data);

  // Line store write port follows the input counters.
  assign wslot = in_row[mhc_pkg::SLOT_W-1:0];
  assign waddr = in_col;
  assign wdata = raw_pixel;

  // Classify the accepted item and step the counters.
  always_comb begin
    in_col_next  = in_col;
    in_row_next  = in_row;
    in_done_next = in_done;
    out_col_next = out_col;
    out_row_next = out_row;
    diff_next    = diff;
    we           = 1'b0;
    emit         = 1'b0;
    pre          = 1'b0;
    eof          = (WW'(out_col) == wid_m1) && (mhc_pkg::DIM_W'(out_row) == hgt_m1);
    if (acc) begin
      if (cmd == mhc_pkg::CMD_PIXEL) begin
        if (!in_done) begin
          we = 1'b1;
          if (WW'(in_col) == wid_m1) begin
            in_col_next = '0;
            if (mhc_pkg::DIM_W'(in_row) == hgt_m1) begin
              in_done_next = 1'b1;
            end else begin
              in_row_next = in_row + mhc_pkg::ROW_W'(1);
            end
          end else begin
            in_col_next = in_col + AW'(1);
          end
          if (diff >= lag) begin
            emit = 1'b1;
          end else begin
            diff_next = diff + LGW'(1);
            pre = (in_row == mhc_pkg::ROW_W'(2)) && (in_col < AW'(2));
          end
        end
      end else if (in_done) begin
        emit      = 1'b1;
        diff_next = diff - LGW'(1);
      end
    end
    if (emit) begin
      if (WW'(out_col) == wid_m1) begin
        out_col_next = '0;
        out_row_next = out_row + mhc_pkg::ROW_W'(1);
      end else begin
        out_col_next = out_col + AW'(1);
      end
      // The frame's last result restarts every counter.
      if (eof) begin
        in_col_next  = '0;
        in_row_next  = '0;
        in_done_next = 1'b0;
        out_col_next = '0;
        out_row_next = '0;
        diff_next    = '0;
      end
    end
    push = emit || pre;
  end

  // Column to fetch and the row base of the window it belongs to.
  always_comb begin
    c0   = (out_col == AW'(0));
    c1   = (out_col == AW'(1));
    ce0  = (WW'(out_col) == wid_m1);
    ce1  = (WW'(out_col) == wid_m2);
    wrap = !(WW'(out_col) < wid_m2);
    if (emit) begin
      if (wrap) begin
        job_col = ce1 ? AW'(0) : AW'(1);
        rb      = mhc_pkg::DIM_W'(out_row) + mhc_pkg::DIM_W'(1);
      end else begin
        job_col = out_col + AW'(2);
        rb      = mhc_pkg::DIM_W'(out_row);
      end
    end else begin
      job_col = in_col;
      rb      = '0;
    end
    r0  = (rb == mhc_pkg::DIM_W'(0));
    r1  = (rb == mhc_pkg::DIM_W'(1));
    re0 = (rb == hgt_m1);
    re1 = (rb == hgt_m2);
    rb3 = rb[mhc_pkg::SLOT_W-1:0];
  end

  // Mirrored row slots and mirrored column picks of the window.
  always_comb begin
    job.emit = emit;
    job.eof  = eof;
    job.rpar = out_row[0];
    job.cpar = out_col[0];
    job.slot[0] = r0 ? 3'd2 : (r1 ? rb3 : rb3 - 3'd2);
    job.slot[1] = r0 ? 3'd1 : rb3 - 3'd1;
    job.slot[2] = rb3;
    job.slot[3] = re0 ? rb3 - 3'd1 : rb3 + 3'd1;
    job.slot[4] = re0 ? rb3 - 3'd2 : (re1 ? rb3 : rb3 + 3'd2);
    job.sel[0]  = c0 ? 3'd0 : (c1 ? 3'd2 : 3'd4);
    job.sel[1]  = c0 ? 3'd1 : 3'd3;
    job.sel[2]  = 3'd2;
    job.sel[3]  = ce0 ? 3'd3 : 3'd1;
    job.sel[4]  = ce0 ? 3'd4 : (ce1 ? 3'd2 : 3'd0);
  end

  // Configuration registers and counters; a register write restarts the frame.
  always_ff @(posedge clk) begin
    if (rst) begin
      wid     <= WW'(WID_RST);
      hgt     <= mhc_pkg::DIM_W'(mhc_pkg::HEIGHT_RESET);
      in_col  <= '0;
      in_row  <= '0;
      in_done <= 1'b0;
      out_col <= '0;
      out_row <= '0;
      diff    <= '0;
    end else if (cfg_wr && ((cfg_index == mhc_pkg::REG_IMAGE_WIDTH) ||
                            (cfg_index == mhc_pkg::REG_IMAGE_HEIGHT))) begin
      if (cfg_index == mhc_pkg::REG_IMAGE_WIDTH) begin
        if (cfg_data < mhc_pkg::DIM_W'(mhc_pkg::MIN_DIM)) begin
          wid <= WW'(mhc_pkg::MIN_DIM);
        end else if (cfg_ext > CW'(MAX_WIDTH)) begin
          wid <= WW'(MAX_WIDTH);
        end else begin
          wid <= WW'(cfg_data);
        end
      end else begin
        if (cfg_data < mhc_pkg::DIM_W'(mhc_pkg::MIN_DIM)) begin
          hgt <= mhc_pkg::DIM_W'(mhc_pkg::MIN_DIM);
        end else if (cfg_data > mhc_pkg::DIM_W'(mhc_pkg::HEIGHT_LIMIT)) begin
          hgt <= mhc_pkg::DIM_W'(mhc_pkg::HEIGHT_LIMIT);
        end else begin
          hgt <= cfg_data;
        end
      end
      in_col  <= '0;
      in_row  <= '0;
      in_done <= 1'b0;
      out_col <= '0;
      out_row <= '0;
      diff    <= '0;
    end else begin
      in_col  <= in_col_next;
      in_row  <= in_row_next;
      in_done <= in_done_next;
      out_col <= out_col_next;
      out_row <= out_row_next;
      diff    <= diff_next;
    end
  end

endmodule

// File: hdl/mhc_back.sv
// Back half: column fetch, 5x5 window, Malvar-He-Cutler kernels and output register.
module mhc_back (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  q_empty,
  input  mhc_pkg::job_t                         head,
  output logic                                  pop,
  output logic                                  re,
  input  logic [mhc_pkg::LINE_SLOTS-1:0][7:0]   rdata,
  input  logic                                  out_stall,
  output logic                                  out_valid,
  output logic [7:0]                            red,
  output logic [7:0]                            green,
  output logic [7:0]                            blue,
  output logic                                  end_of_frame
);

  localparam int K = mhc_pkg::KSIZE;
  localparam int SW = mhc_pkg::SUM_W;

  logic                               adv;
  logic                               rd_v, wn_v, sm_v;
  mhc_pkg::job_t                      rd_job, wn_job;
  logic [K-1:0][K-1:0][7:0]           cols;
  logic [K-1:0][7:0]                  newcol;
  logic [K-1:0][K-1:0][7:0]           p;
  logic signed [SW-1:0]               a, b, dg, h, v, c;
  logic signed [SW-1:0]               s_cross, s_square, s_horiz, s_vert;
  logic signed [SW-1:0]               sm_cross, sm_square, sm_horiz, sm_vert;
  logic [7:0]                         sm_center;
  logic                               sm_rpar, sm_cpar, sm_eof;
  logic [7:0]                         v_cross, v_square, v_horiz, v_vert;

  // Round half up from sixteenths and clip to a byte.
  function automatic logic [7:0] round_clip(input logic signed [SW-1:0] s);
    logic signed [SW-1:0] t;
    t = s + SW'(8);
    if (t < 0) begin
      return 8'd0;
    end else if (t[SW-2:4] > (SW - 5)'(255)) begin
      return 8'd255;
    end else begin
      return t[11:4];
    end
  endfunction

  // The whole pipeline moves whenever the output register can take a transfer.
  assign adv = !out_valid || !out_stall;
  assign pop = adv && !q_empty;
  assign re  = adv;

  // New column, each window row taken from its mirrored slot.
  always_comb begin
    for (int i = 0; i < K; i++) begin
      newcol[i] = rdata[rd_job.slot[i]];
    end
  end

  // Window with mirrored columns picked from the column history.
  always_comb begin
    for (int i = 0; i < K; i++) begin
      for (int j = 0; j < K; j++) begin
        p[i][j] = cols[wn_job.sel[j]][i];
      end
    end
  end

  // Shared partial sums and the four non-trivial kernels.
  always_comb begin
    a  = SW'(p[0][2]) + SW'(p[4][2]);
    b  = SW'(p[2][0]) + SW'(p[2][4]);
    dg = SW'(p[1][1]) + SW'(p[1][3]) + SW'(p[3][1]) + SW'(p[3][3]);
    h  = SW'(p[2][1]) + SW'(p[2][3]);
    v  = SW'(p[1][2]) + SW'(p[3][2]);
    c  = SW'(p[2][2]);
    s_cross  = ((h + v) <<< 2) - ((a + b) <<< 1) + (c <<< 3);
    s_square = (dg <<< 2) - ((a + b) <<< 1) - (a + b) + (c <<< 3) + (c <<< 2);
    s_horiz  = a - (dg <<< 1) - (b <<< 1) + (h <<< 3) + (c <<< 3) + (c <<< 1);
    s_vert   = b - (dg <<< 1) - (a <<< 1) + (v <<< 3) + (c <<< 3) + (c <<< 1);
  end

  assign v_cross  = round_clip(sm_cross);
  assign v_square = round_clip(sm_square);
  assign v_horiz  = round_clip(sm_horiz);
  assign v_vert   = round_clip(sm_vert);

  // Stage valids.
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_v      <= 1'b0;
      wn_v      <= 1'b0;
      sm_v      <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      rd_v      <= !q_empty;
      wn_v      <= rd_v && rd_job.emit;
      sm_v      <= wn_v;
      out_valid <= sm_v;
    end
  end

  // Stage payloads.
  always_ff @(posedge clk) begin
    if (adv) begin
      rd_job <= head;
      wn_job <= rd_job;
      if (rd_v) begin
        cols <= {cols[K-2:0], newcol};
      end
      sm_cross  <= s_cross;
      sm_square <= s_square;
      sm_horiz  <= s_horiz;
      sm_vert   <= s_vert;
      sm_center <= p[2][2];
      sm_rpar   <= wn_job.rpar;
      sm_cpar   <= wn_job.cpar;
      sm_eof    <= wn_job.eof;
      // Kernel choice follows the GRBG site of the pixel.
      end_of_frame <= sm_eof;
      if (sm_rpar == sm_cpar) begin
        green <= sm_center;
        red   <= sm_rpar ? v_vert : v_horiz;
        blue  <= sm_rpar ? v_horiz : v_vert;
      end else if (!sm_rpar) begin
        red   <= sm_center;
        green <= v_cross;
        blue  <= v_square;
      end else begin
        red   <= v_square;
        green <= v_cross;
        blue  <= sm_center;
      end
    end
  end

endmodule

// File: hdl/mhc_bayer_demosaic.sv
// Top level of the Malvar-He-Cutler 5x5 demosaic for GRBG Bayer streams.
// The block takes one item per clock while in_stall is low and gives one RGB
// result per pixel; result k leaves with input item k+2W+2 and passes the job
// queue, the fetch, window and kernel registers and the output register.
// The rate is set by the line store, which is written once and read at one
// column across all eight row slots each cycle; a four-entry job queue lets
// input continue while a result waits at the output. The line store is not
// cleared after reset: every result reads only samples of its own frame.
// Send 2W+2 flush items after each frame; extra flushes and pixels sent
// during the drain are dropped. Configure only while the block is idle.
module mhc_bayer_demosaic #(
  parameter int MAX_WIDTH = 4096
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [7:0]                  cfg_index,
  input  logic [mhc_pkg::DIM_W-1:0]   cfg_data,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        cmd,
  input  logic [7:0]                  raw_pixel,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [7:0]                  red,
  output logic [7:0]                  green,
  output logic [7:0]                  blue,
  output logic                        end_of_frame
);

  localparam int AW = $clog2(MAX_WIDTH);
  localparam int DW = $bits(mhc_pkg::job_t) + AW;

  logic                                  acc;
  logic                                  we;
  logic [mhc_pkg::SLOT_W-1:0]            wslot;
  logic [AW-1:0]                         waddr;
  logic [7:0]                            wdata;
  logic                                  push, pop, q_full, q_empty, re;
  mhc_pkg::job_t                         job, head;
  logic [AW-1:0]                         job_col, head_col;
  logic [DW-1:0]                         q_din, q_dout;
  logic [mhc_pkg::LINE_SLOTS-1:0][7:0]   rdata;

  assign cfg_ready = 1'b1;
  assign in_stall  = q_full;
  assign acc       = in_valid && !in_stall;
  assign q_din     = {job, job_col};
  assign {head, head_col} = q_dout;

  mhc_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .acc       (acc),
    .cmd       (cmd),
    .raw_pixel (raw_pixel),
    .we        (we),
    .wslot     (wslot),
    .waddr     (waddr),
    .wdata     (wdata),
    .push      (push),
    .job       (job),
    .job_col   (job_col)
  );

  mhc_linebuf #(.MAX_WIDTH(MAX_WIDTH)) u_linebuf (
    .clk   (clk),
    .we    (we),
    .wslot (wslot),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (head_col),
    .rdata (rdata)
  );

  mhc_jobq #(.DW(DW)) u_jobq (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .din   (q_din),
    .pop   (pop),
    .dout  (q_dout),
    .full  (q_full),
    .empty (q_empty)
  );

  mhc_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_empty      (q_empty),
    .head         (head),
    .pop          (pop),
    .re           (re),
    .rdata        (rdata),
    .out_stall    (out_stall),
    .out_valid    (out_valid),
    .red          (red),
    .green        (green),
    .blue         (blue),
    .end_of_frame (end_of_frame)
  );

endmodule

// File: hdl/mhc_checker.sv
// Port-level checks of the demosaic block and their binding to the top level.
module mhc_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] red,
  input logic [7:0] green,
  input logic [7:0] blue,
  input logic       end_of_frame
);

  // A stalled result stays offered and unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable({red, green, blue, end_of_frame}))
    else $error("stalled result changed or vanished");

  // After reset the output register is empty and the queue is not full.
  a_reset_clear: assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall)
    else $error("block not empty after reset");

  // The queue can only fill up after an input transfer.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(in_stall) |-> $past(in_valid && !in_stall))
    else $error("input stall raised without an input transfer");

endmodule

bind mhc_bayer_demosaic mhc_checker u_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_stall     (in_stall),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .red          (red),
  .green        (green),
  .blue         (blue),
  .end_of_frame (end_of_frame)
);
